// ----- sv/ipv4_udp_receive_checker_top_assert.svh -----
// Assertion macros for the IPv4/UDP receive checker.
// Included by the top level; no other dependencies.
`ifndef IPV4_UDP_RECEIVE_CHECKER_TOP_ASSERT_SVH
`define IPV4_UDP_RECEIVE_CHECKER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define IURC_ASSERT_IMPLY(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("iurc assertion failed");
`define IURC_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("iurc assertion failed");
`else
`define IURC_ASSERT_IMPLY(label, clk, rst_n, prop)
`define IURC_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- sv/iurc_pkg.sv -----
// Shared types, constants and helpers of the IPv4/UDP receive checker.
// No dependencies.
`default_nettype none
package iurc_pkg;

  localparam logic [3:0]  IP_VERSION_FOUR  = 4'd4;
  localparam logic [3:0]  IP_HEADER_WORDS  = 4'd5;
  localparam logic [7:0]  UDP_PROTOCOL     = 8'd17;
  localparam logic [15:0] IP_HEADER_BYTES  = 16'd20;
  localparam logic [15:0] MIN_PACKET_BYTES = 16'd28;

  localparam logic [15:0] POS_VERSION      = 16'd0;
  localparam logic [15:0] POS_TOTAL_LEN_LO = 16'd3;
  localparam logic [15:0] POS_PROTOCOL     = 16'd9;
  localparam logic [15:0] POS_HDR_CHECK_HI = 16'd10;
  localparam logic [15:0] POS_HDR_CHECK_LO = 16'd11;
  localparam logic [15:0] POS_SOURCE       = 16'd12;
  localparam logic [15:0] POS_DEST         = 16'd16;
  localparam logic [15:0] POS_PORT_LO      = 16'd23;
  localparam logic [15:0] POS_ULEN_LO      = 16'd25;
  localparam logic [15:0] POS_UCHK_HI      = 16'd26;
  localparam logic [15:0] POS_UCHK_LO      = 16'd27;

  localparam logic [15:0] RX_PORT_RESET    = 16'd68;
  localparam logic [15:0] MAX_LEN_RESET    = 16'd576;
  localparam logic [15:0] ALL_ONES16       = 16'hffff;

  localparam logic CFG_RX_PORT = 1'b0;
  localparam logic CFG_MAX_LEN = 1'b1;

  // queue depths are powers of two so the pointers wrap on their own
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;
  localparam logic [QCNT_W-1:0] QFULL_COUNT = QCNT_W'(QDEPTH);

  typedef enum logic [2:0] {
    VERDICT_ACCEPTED = 3'd0,
    VERDICT_SHORT    = 3'd1,
    VERDICT_FIELD    = 3'd2,
    VERDICT_IP_SUM   = 3'd3,
    VERDICT_UDP_SUM  = 3'd4
  } verdict_t;

  typedef struct packed {
    logic [15:0] byte_count;
    logic [19:0] header_sum;
    logic [31:0] datagram_sum;
    logic [7:0]  version_ihl;
    logic [7:0]  protocol;
    logic [15:0] total_length;
    logic [15:0] header_check;
    logic [31:0] source;
    logic [31:0] destination;
    logic [15:0] udp_port;
    logic [15:0] udp_length;
    logic [15:0] udp_check;
  } record_t;

  typedef struct packed {
    logic    valid;
    record_t rec;
  } rec_push_t;

  typedef struct packed {
    logic    empty;
    record_t rec;
  } rec_head_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [15:0] payload_length;
    logic [31:0] source;
    logic [31:0] destination;
  } result_t;

  function automatic logic [15:0] fold16(input logic [31:0] s);
    logic [16:0] f1;
    logic [16:0] f2;
    f1 = {1'b0, s[15:0]} + {1'b0, s[31:16]};
    f2 = {1'b0, f1[15:0]} + {16'h0000, f1[16]};
    return f2[15:0];
  endfunction

endpackage
`default_nettype wire

// ----- sv/iurc_front.sv -----
// Front end: counts packet bytes, captures header fields and runs both sums.
// Hands a finished packet record to the record queue. Uses iurc_pkg.
`default_nettype none
module iurc_front import iurc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        take,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  input  wire logic [15:0] max_len,
  output rec_push_t        push
);

  record_t     st_r, st_nxt, st_upd;
  logic [7:0]  pend_r, pend_nxt, pend_upd;
  logic [15:0] pos;
  logic [15:0] lane;
  logic [15:0] word;
  logic        store;

  assign pos   = st_r.byte_count;
  assign lane  = pos[0] ? {8'h00, data_byte} : {data_byte, 8'h00};
  assign word  = {pend_r, data_byte};
  assign store = take && (pos < max_len);

  always_comb begin
    st_upd   = st_r;
    pend_upd = pend_r;
    if (store) begin
      if (pos < IP_HEADER_BYTES && pos != POS_HDR_CHECK_HI && pos != POS_HDR_CHECK_LO) begin
        st_upd.header_sum = st_r.header_sum + {4'h0, lane};
      end
      if ((pos >= POS_SOURCE && pos < IP_HEADER_BYTES) ||
          (pos >= IP_HEADER_BYTES && pos < st_r.total_length &&
           pos != POS_UCHK_HI && pos != POS_UCHK_LO)) begin
        st_upd.datagram_sum = st_r.datagram_sum + {16'h0000, lane};
      end
      if (pos == POS_VERSION) st_upd.version_ihl = data_byte;
      if (pos == POS_PROTOCOL) st_upd.protocol = data_byte;
      if (pos >= POS_SOURCE && pos < POS_DEST) begin
        st_upd.source = {st_r.source[23:0], data_byte};
      end
      if (pos >= POS_DEST && pos < IP_HEADER_BYTES) begin
        st_upd.destination = {st_r.destination[23:0], data_byte};
      end
      if (pos == POS_TOTAL_LEN_LO) st_upd.total_length = word;
      if (pos == POS_HDR_CHECK_LO) st_upd.header_check = word;
      if (pos == POS_PORT_LO)      st_upd.udp_port     = word;
      if (pos == POS_ULEN_LO)      st_upd.udp_length   = word;
      if (pos == POS_UCHK_LO)      st_upd.udp_check    = word;
      pend_upd = data_byte;
      st_upd.byte_count = pos + 16'd1;
    end
    push.valid = take && last_byte;
    push.rec   = st_upd;
    if (push.valid) begin
      st_nxt   = '0;
      pend_nxt = '0;
    end else begin
      st_nxt   = st_upd;
      pend_nxt = pend_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= '0;
      pend_r <= '0;
    end else begin
      st_r   <= st_nxt;
      pend_r <= pend_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/iurc_recq.sv -----
// Short queue of finished packet records between front and back end.
// Uses iurc_pkg.
`default_nettype none
module iurc_recq import iurc_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire rec_push_t push,
  output logic           full,
  input  wire logic      pop,
  output rec_head_t      head
);

  record_t           mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full       = (cnt_r == QFULL_COUNT);
  assign head.empty = (cnt_r == '0);
  assign head.rec   = mem_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && !head.empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/iurc_back.sv -----
// Back end: judges each packet record in two steps and queues the results.
// Uses iurc_pkg.
`default_nettype none
module iurc_back import iurc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire rec_head_t   head,
  output logic             head_pop,
  input  wire logic [15:0] rx_port,
  input  wire logic [15:0] max_len,
  output result_t          res,
  output logic             res_empty,
  input  wire logic        res_pop
);

  typedef struct packed {
    logic        short_f;
    logic        field_f;
    logic [15:0] hdr_fold;
    logic [15:0] dgram_fold;
    logic [15:0] header_check;
    logic [15:0] udp_length;
    logic [15:0] udp_check;
    logic [15:0] total_length;
    logic [31:0] source;
    logic [31:0] destination;
  } judge_t;

  judge_t            s1_r, s1_nxt;
  logic              s1_v_r, s1_v_nxt;
  logic              s1_ld;
  record_t           r;
  logic [15:0]       udp_fold;
  logic [15:0]       ip_want, udp_want;
  result_t           res_nxt;

  result_t           oq_r [QDEPTH];
  logic [QPTR_W-1:0] oq_wr_r, oq_wr_nxt;
  logic [QPTR_W-1:0] oq_rd_r, oq_rd_nxt;
  logic [QCNT_W-1:0] oq_cnt_r, oq_cnt_nxt;
  logic              oq_full, oq_push, oq_pop;

  assign oq_full   = (oq_cnt_r == QFULL_COUNT);
  assign res_empty = (oq_cnt_r == '0);
  assign res       = oq_r[oq_rd_r];
  assign oq_push   = s1_v_r && !oq_full;
  assign oq_pop    = res_pop && !res_empty;
  assign s1_ld     = !s1_v_r || !oq_full;
  assign head_pop  = s1_ld && !head.empty;
  assign r         = head.rec;

  always_comb begin
    s1_nxt.short_f = (r.byte_count < MIN_PACKET_BYTES) || (r.byte_count < r.total_length);
    s1_nxt.field_f = (r.protocol != UDP_PROTOCOL) ||
                     (r.version_ihl[7:4] != IP_VERSION_FOUR) ||
                     (r.version_ihl[3:0] != IP_HEADER_WORDS) ||
                     (r.udp_port != rx_port) ||
                     (r.total_length > max_len) ||
                     (r.total_length < MIN_PACKET_BYTES) ||
                     (r.udp_length != r.total_length - IP_HEADER_BYTES);
    s1_nxt.hdr_fold     = fold16({12'h000, r.header_sum});
    s1_nxt.dgram_fold   = fold16(r.datagram_sum);
    s1_nxt.header_check = r.header_check;
    s1_nxt.udp_length   = r.udp_length;
    s1_nxt.udp_check    = r.udp_check;
    s1_nxt.total_length = r.total_length;
    s1_nxt.source       = r.source;
    s1_nxt.destination  = r.destination;
    if (head_pop) begin
      s1_v_nxt = 1'b1;
    end else if (oq_push) begin
      s1_v_nxt = 1'b0;
    end else begin
      s1_v_nxt = s1_v_r;
    end
  end

  always_comb begin
    udp_fold = fold16({16'h0000, s1_r.dgram_fold} + {24'h000000, UDP_PROTOCOL} +
                      {16'h0000, s1_r.udp_length});
    ip_want  = ~s1_r.hdr_fold;
    udp_want = ~udp_fold;
    res_nxt.source         = s1_r.source;
    res_nxt.destination    = s1_r.destination;
    res_nxt.payload_length = '0;
    if (s1_r.short_f) begin
      res_nxt.verdict = VERDICT_SHORT;
    end else if (s1_r.field_f) begin
      res_nxt.verdict = VERDICT_FIELD;
    end else if (s1_r.header_check != ip_want) begin
      res_nxt.verdict = VERDICT_IP_SUM;
    end else if (s1_r.udp_check != '0 && s1_r.udp_check != udp_want &&
                 !(udp_want == '0 && s1_r.udp_check == ALL_ONES16)) begin
      res_nxt.verdict = VERDICT_UDP_SUM;
    end else begin
      res_nxt.verdict        = VERDICT_ACCEPTED;
      res_nxt.payload_length = s1_r.total_length - MIN_PACKET_BYTES;
    end
    oq_wr_nxt  = oq_push ? oq_wr_r + 1'b1 : oq_wr_r;
    oq_rd_nxt  = oq_pop  ? oq_rd_r + 1'b1 : oq_rd_r;
    oq_cnt_nxt = oq_cnt_r + QCNT_W'(oq_push) - QCNT_W'(oq_pop);
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      s1_r <= s1_nxt;
    end
    if (oq_push) begin
      oq_r[oq_wr_r] <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      oq_wr_r  <= '0;
      oq_rd_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      s1_v_r   <= s1_v_nxt;
      oq_wr_r  <= oq_wr_nxt;
      oq_rd_r  <= oq_rd_nxt;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/ipv4_udp_receive_checker_top.sv -----
// IPv4/UDP receive checker, top level: configuration registers and wiring.
// Uses iurc_pkg, iurc_front, iurc_recq, iurc_back and the assertion header.
//
// Input channel: one packet byte per item on in_data_byte, from the first
// byte of the IP header, with in_last_byte high on the final byte. Push while
// in_full is low; then one byte is taken every cycle, with no gap between
// packets. Result channel: one item per packet, queued once judged: verdict,
// UDP payload length (zero unless accepted) and the two addresses. The oldest
// result waits on out_* while out_empty is low; pop takes it.
// Throughput: one byte per cycle while in_full is low, set by the front
// end's running sums; the judge stage takes one packet per cycle while the
// result queue has room. A result passes the record queue, judge register
// and result queue in turn. A stalled result side fills a two-entry result
// queue, the judge register and then a two-entry record queue; only then
// does in_full rise, and it drops as soon as a record moves on.
// Configuration: cfg_wr_en writes cfg_data into the register at cfg_index
// (0 destination port, 1 maximum total length); write while idle.
// Reset clears all queues and packet state and restores port 68, maximum 576.
`default_nettype none
`include "ipv4_udp_receive_checker_top_assert.svh"
module ipv4_udp_receive_checker_top import iurc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_last_byte,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [2:0]       out_verdict,
  output logic [15:0]      out_payload_length,
  output logic [31:0]      out_source_address,
  output logic [31:0]      out_destination_address,
  input  wire logic        cfg_wr_en,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] rx_port_r, rx_port_nxt;
  logic [15:0] max_len_r, max_len_nxt;
  logic        take;
  logic        rq_full;
  logic        rq_pop;
  rec_push_t   rq_push;
  rec_head_t   rq_head;
  result_t     res;

  always_comb begin
    rx_port_nxt = rx_port_r;
    max_len_nxt = max_len_r;
    if (cfg_wr_en) begin
      case (cfg_index[0])
        CFG_RX_PORT: rx_port_nxt = cfg_data;
        CFG_MAX_LEN: max_len_nxt = cfg_data;
        default:     rx_port_nxt = rx_port_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_port_r <= RX_PORT_RESET;
      max_len_r <= MAX_LEN_RESET;
    end else begin
      rx_port_r <= rx_port_nxt;
      max_len_r <= max_len_nxt;
    end
  end

  assign in_full = rq_full;
  assign take    = in_push && !rq_full;

  iurc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .data_byte (in_data_byte),
    .last_byte (in_last_byte),
    .max_len   (max_len_r),
    .push      (rq_push)
  );

  iurc_recq u_recq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .full  (rq_full),
    .pop   (rq_pop),
    .head  (rq_head)
  );

  iurc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (rq_head),
    .head_pop  (rq_pop),
    .rx_port   (rx_port_r),
    .max_len   (max_len_r),
    .res       (res),
    .res_empty (out_empty),
    .res_pop   (out_pop)
  );

  assign out_verdict             = res.verdict;
  assign out_payload_length      = res.payload_length;
  assign out_source_address      = res.source;
  assign out_destination_address = res.destination;

  `IURC_ASSERT_IMPLY(a_last_queues_record, clk, rst_n, (take && in_last_byte) |=> !rq_head.empty)
  `IURC_ASSERT_NEVER(a_reject_no_payload, clk, rst_n,
                     !out_empty && res.verdict != VERDICT_ACCEPTED && out_payload_length != '0)
  `IURC_ASSERT_NEVER(a_push_needs_room, clk, rst_n, rq_push.valid && rq_full)

endmodule
`default_nettype wire
